// ----- hw/rtl/mra_pkg.sv -----
`timescale 1ns / 1ps
// mra_pkg: command codes and the per-stage control group of the modular ring alu
// no dependencies; used by every module of the block
package mra_pkg;

    // operation codes carried on i_cmd
    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_R2S = 3'd3,
        CMD_S2R = 3'd4
    } t_cmd;

    // control that travels with each transaction down the pipeline
    typedef struct packed {
        logic err;       // range error or zero modulus, result forced to 0
        logic mul_path;  // result comes from the multiply/reduce chain
        logic neg_fix;   // negative signed input: take modulus minus residue
    } t_ctl;

endpackage

// ----- hw/rtl/mra_front.sv -----
`timescale 1ns / 1ps
// mra_front: decode stage: range checks, add, subtract, signed lift, and
// operand setup for the multiply/reduce chain; uses mra_pkg
module mra_front #(
    parameter int W = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  logic [2:0]        i_cmd,
    input  logic [W-1:0]      i_a,
    input  logic [W-1:0]      i_b,
    input  logic [W-1:0]      i_mod,
    output logic              o_valid,
    output mra_pkg::t_ctl     o_ctl,
    output logic [W-1:0]      o_direct,
    output logic [W-1:0]      o_x,
    output logic [W-1:0]      o_y
);

    logic              r_valid;
    mra_pkg::t_ctl     r_ctl, n_ctl;
    logic [W-1:0]      r_direct, n_direct;
    logic [W-1:0]      r_x, n_x;
    logic [W-1:0]      r_y, n_y;

    logic [W:0]        sum_ab;
    logic [W-1:0]      add_res;
    logic [W-1:0]      sub_res;
    logic [W-1:0]      lift_res;
    logic [W-1:0]      half_m;
    logic [W-1:0]      mag_a;
    logic              a_ok;
    logic              b_ok;
    logic              keep;
    logic              m_zero;

    // shared arithmetic for the direct commands
    always_comb begin
        a_ok     = i_a < i_mod;
        b_ok     = i_b < i_mod;
        m_zero   = (i_mod == '0);
        sum_ab   = {1'b0, i_a} + {1'b0, i_b};
        add_res  = (sum_ab >= {1'b0, i_mod}) ? W'(sum_ab - {1'b0, i_mod}) : sum_ab[W-1:0];
        // wraps to modulus - (b - a) when b > a
        sub_res  = (i_a >= i_b) ? (i_a - i_b) : (i_a - i_b + i_mod);
        half_m   = i_mod >> 1;
        keep     = i_mod[0] ? (i_a <= half_m) : (i_a < half_m);
        lift_res = keep ? i_a : (i_a - i_mod);
        // two's complement magnitude; the most negative value maps to itself
        mag_a    = i_a[W-1] ? (~i_a + W'(1)) : i_a;
    end

    // per-command decode
    always_comb begin
        n_ctl    = '0;
        n_direct = '0;
        n_x      = '0;
        n_y      = '0;
        case (i_cmd)
            mra_pkg::CMD_ADD: begin
                n_ctl.err = ~(a_ok & b_ok);
                n_direct  = add_res;
            end
            mra_pkg::CMD_SUB: begin
                n_ctl.err = ~(a_ok & b_ok);
                n_direct  = sub_res;
            end
            mra_pkg::CMD_MUL: begin
                n_ctl.err      = ~(a_ok & b_ok);
                n_ctl.mul_path = 1'b1;
                n_x            = i_a;
                n_y            = i_b;
            end
            mra_pkg::CMD_R2S: begin
                n_ctl.err = ~a_ok;
                n_direct  = lift_res;
            end
            mra_pkg::CMD_S2R: begin
                // residue of the magnitude as one times magnitude
                n_ctl.mul_path = 1'b1;
                n_ctl.neg_fix  = i_a[W-1];
                n_x            = (i_mod == W'(1)) ? '0 : W'(1);
                n_y            = mag_a;
            end
            default: begin
                n_ctl = '0;
            end
        endcase
        if (m_zero) begin
            n_ctl.err = 1'b1;
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ctl    <= n_ctl;
            r_direct <= n_direct;
            r_x      <= n_x;
            r_y      <= n_y;
        end
    end

    assign o_valid  = r_valid;
    assign o_ctl    = r_ctl;
    assign o_direct = r_direct;
    assign o_x      = r_x;
    assign o_y      = r_y;

endmodule

// ----- hw/rtl/mra_step.sv -----
`timescale 1ns / 1ps
// mra_step: one bit of the interleaved modular multiply, acc = 2*acc + bit*x mod m,
// taking the multiplier MSB first; uses mra_pkg
module mra_step #(
    parameter int W = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  mra_pkg::t_ctl     i_ctl,
    input  logic [W-1:0]      i_direct,
    input  logic [W-1:0]      i_x,
    input  logic [W-1:0]      i_y,
    input  logic [W-1:0]      i_acc,
    input  logic [W-1:0]      i_mod,
    output logic              o_valid,
    output mra_pkg::t_ctl     o_ctl,
    output logic [W-1:0]      o_direct,
    output logic [W-1:0]      o_x,
    output logic [W-1:0]      o_y,
    output logic [W-1:0]      o_acc
);

    logic              r_valid;
    mra_pkg::t_ctl     r_ctl;
    logic [W-1:0]      r_direct;
    logic [W-1:0]      r_x;
    logic [W-1:0]      r_y;
    logic [W-1:0]      r_acc, n_acc;

    logic [W:0]        dbl;
    logic [W:0]        dbl_red;
    logic [W:0]        tot;

    // double and reduce, then add the selected multiplicand and reduce
    always_comb begin
        dbl     = {i_acc, 1'b0};
        dbl_red = (dbl >= {1'b0, i_mod}) ? (dbl - {1'b0, i_mod}) : dbl;
        tot     = dbl_red + {1'b0, (i_y[W-1] ? i_x : '0)};
        n_acc   = (tot >= {1'b0, i_mod}) ? W'(tot - {1'b0, i_mod}) : tot[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ctl    <= i_ctl;
            r_direct <= i_direct;
            r_x      <= i_x;
            r_y      <= {i_y[W-2:0], 1'b0};
            r_acc    <= n_acc;
        end
    end

    assign o_valid  = r_valid;
    assign o_ctl    = r_ctl;
    assign o_direct = r_direct;
    assign o_x      = r_x;
    assign o_y      = r_y;
    assign o_acc    = r_acc;

endmodule

// ----- hw/rtl/modular_ring_alu.sv -----
`timescale 1ns / 1ps
// modular_ring_alu: pipelined alu over the integers modulo a configured modulus
// depends on mra_pkg, mra_front, mra_step
//
// channel   direction  handshake                 payload
// in        sink       i_valid / o_stall         i_cmd, i_operand_a, i_operand_b
// out       source     o_valid / i_stall         o_result, o_range_error
// cfg       sink       i_cfg_valid / o_cfg_ready i_cfg_data (modulus)
//
// one transaction enters per cycle unless the output stalls; the decode stage feeds the
// chain of one-bit modular multiply steps (one per multiplier bit) and the output register.
// reset clears all valid bits and sets the modulus to 2^32.
// a stall on the output freezes the whole pipeline; bubbles travel with the
// transactions and are not squeezed out.
module modular_ring_alu #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [2:0]            i_cmd,
    input  logic [DATA_WIDTH-1:0] i_operand_a,
    input  logic [DATA_WIDTH-1:0] i_operand_b,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [DATA_WIDTH-1:0] o_result,
    output logic                  o_range_error,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [DATA_WIDTH-1:0] i_cfg_data
);

    localparam int W = DATA_WIDTH;

    logic [W-1:0]      r_modulus;
    logic              r_out_valid;
    logic [W-1:0]      r_result, n_result;
    logic              r_range_error;
    logic              adv;

    logic              s_valid  [0:W];
    mra_pkg::t_ctl     s_ctl    [0:W];
    logic [W-1:0]      s_direct [0:W];
    logic [W-1:0]      s_x      [0:W];
    logic [W-1:0]      s_y      [0:W];
    logic [W-1:0]      s_acc    [0:W];

    // pipeline moves unless a finished result is held by the sink
    assign adv         = ~r_out_valid | ~i_stall;
    assign o_stall     = ~adv;
    assign o_cfg_ready = 1'b1;

    // modulus register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= W'(64'h0000_0001_0000_0000);
        end else if (i_cfg_valid) begin
            r_modulus <= i_cfg_data;
        end
    end

    // decode stage
    mra_front #(.W(W)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_valid  (i_valid),
        .i_cmd    (i_cmd),
        .i_a      (i_operand_a),
        .i_b      (i_operand_b),
        .i_mod    (r_modulus),
        .o_valid  (s_valid[0]),
        .o_ctl    (s_ctl[0]),
        .o_direct (s_direct[0]),
        .o_x      (s_x[0]),
        .o_y      (s_y[0])
    );
    assign s_acc[0] = '0;

    // one step per multiplier bit
    for (genvar k = 0; k < W; k++) begin : g_step
        mra_step #(.W(W)) u_step (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_adv    (adv),
            .i_valid  (s_valid[k]),
            .i_ctl    (s_ctl[k]),
            .i_direct (s_direct[k]),
            .i_x      (s_x[k]),
            .i_y      (s_y[k]),
            .i_acc    (s_acc[k]),
            .i_mod    (r_modulus),
            .o_valid  (s_valid[k+1]),
            .o_ctl    (s_ctl[k+1]),
            .o_direct (s_direct[k+1]),
            .o_x      (s_x[k+1]),
            .o_y      (s_y[k+1]),
            .o_acc    (s_acc[k+1])
        );
    end

    // final select
    always_comb begin
        if (s_ctl[W].err) begin
            n_result = '0;
        end else if (s_ctl[W].mul_path) begin
            if (s_ctl[W].neg_fix && (s_acc[W] != '0)) begin
                n_result = r_modulus - s_acc[W];
            end else begin
                n_result = s_acc[W];
            end
        end else begin
            n_result = s_direct[W];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= s_valid[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_result      <= n_result;
            r_range_error <= s_ctl[W].err;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_result      = r_result;
    assign o_range_error = r_range_error;

`ifndef ASSERT_OFF
    // an error transaction always carries a zero result
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_range_error |-> o_result == '0)
        else $error("range error with nonzero result");

    // backpressure only while a result is held
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held result");

    // zero modulus flags every result
    a_zero_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (r_modulus == '0) && $stable(r_modulus) |-> o_range_error)
        else $error("zero modulus without range error");
`endif

endmodule

// ----- tb/modular_ring_alu_test.sv -----
`timescale 1ns / 1ps
// modular_ring_alu_test: self-checking testbench for the modular ring alu
// depends on mra_pkg and modular_ring_alu; predicts each result and checks it in order
module modular_ring_alu_test;

    localparam int W = 64;
    localparam int LATENCY = W + 2;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM = 800;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_valid;
    logic         o_stall;
    logic [2:0]   i_cmd;
    logic [W-1:0] i_operand_a;
    logic [W-1:0] i_operand_b;
    logic         o_valid;
    logic         i_stall;
    logic [W-1:0] o_result;
    logic         o_range_error;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [W-1:0] i_cfg_data;

    typedef struct packed {
        logic [W-1:0] result;
        logic         range_error;
    } t_ring_result;

    // directed row: command, operands, and a typed-in answer when obvious
    typedef struct {
        logic [2:0]   cmd;
        logic [W-1:0] a;
        logic [W-1:0] b;
        bit           fixed;
        t_ring_result want;
    } t_row;

    t_ring_result pending_results[$];
    logic [W-1:0] ring_modulus;
    int           error_count;
    int           idle_cycles;
    bit           stall_free;

    modular_ring_alu #(.DATA_WIDTH(W)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_cmd(i_cmd), .i_operand_a(i_operand_a), .i_operand_b(i_operand_b),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_result(o_result), .o_range_error(o_range_error),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // predicted result of one operation under the current modulus
    function automatic t_ring_result ring_predict(logic [2:0] cmd, logic [W-1:0] a,
                                                  logic [W-1:0] b, logic [W-1:0] m);
        t_ring_result r;
        logic [W-1:0] mag;
        logic [W-1:0] rem;
        logic [W:0]   sum;
        logic [2*W-1:0] prod;
        r = '0;
        if (m == 0) begin
            r.range_error = 1'b1;
        end else if (cmd == mra_pkg::CMD_ADD || cmd == mra_pkg::CMD_SUB ||
                     cmd == mra_pkg::CMD_MUL) begin
            if (a >= m || b >= m) begin
                r.range_error = 1'b1;
            end else if (cmd == mra_pkg::CMD_ADD) begin
                sum = {1'b0, a} + {1'b0, b};
                if (sum >= {1'b0, m}) sum = sum - {1'b0, m};
                r.result = sum[W-1:0];
            end else if (cmd == mra_pkg::CMD_SUB) begin
                r.result = (a >= b) ? a - b : m - (b - a);
            end else begin
                prod = {{W{1'b0}}, a} * {{W{1'b0}}, b};
                prod = prod % {{W{1'b0}}, m};
                r.result = prod[W-1:0];
            end
        end else if (cmd == mra_pkg::CMD_R2S) begin
            if (a >= m) r.range_error = 1'b1;
            else if (m[0] ? (a <= m / 2) : (a < m / 2)) r.result = a;
            else r.result = a - m;
        end else if (cmd == mra_pkg::CMD_S2R) begin
            if (a[W-1]) begin
                mag = ~a + 1'b1;
                rem = mag % m;
                r.result = (rem == 0) ? '0 : m - rem;
            end else begin
                r.result = a % m;
            end
        end
        return r;
    endfunction

    // output side: random stall pattern and in-order compare
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result %h err %b", $time, o_result,
                             o_range_error);
                    error_count++;
                end else begin
                    t_ring_result want;
                    want = pending_results.pop_front();
                    if (o_result !== want.result) begin
                        $display("%0t: result expected %h actual %h", $time,
                                 want.result, o_result);
                        error_count++;
                    end
                    if (o_range_error !== want.range_error) begin
                        $display("%0t: range_error expected %b actual %b", $time,
                                 want.range_error, o_range_error);
                        error_count++;
                    end
                end
            end
            i_stall <= stall_free ? 1'b0 : ($urandom_range(0, 3) == 0);
        end
    end

    // watchdog on cycles with no transaction at all
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // one input transaction, held until accepted
    task automatic send_op(logic [2:0] cmd, logic [W-1:0] a, logic [W-1:0] b);
        i_valid     <= 1'b1;
        i_cmd       <= cmd;
        i_operand_a <= a;
        i_operand_b <= b;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(ring_predict(cmd, a, b, ring_modulus));
    endtask

    task automatic idle_gap(int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // wait for the pipeline to drain, then write a new modulus
    task automatic set_modulus(logic [W-1:0] m);
        idle_gap(1);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        ring_modulus = m;
    endtask

    function automatic logic [W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // operand mostly in range, sometimes near the edges or out of range
    function automatic logic [W-1:0] rand_operand(logic [W-1:0] m);
        case ($urandom_range(0, 9))
            0: return rand_word();
            1: return m - 1;
            2: return m;
            3: return '0;
            default: return (m == 0) ? rand_word() : rand_word() % m;
        endcase
    endfunction

    t_row rows[$];
    logic [W-1:0] mod_list[9];

    initial begin
        t_ring_result ok0, err1;
        t_row row;
        int burst;
        logic [2:0] cmd;

        error_count = 0;
        idle_cycles = 0;
        stall_free  = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_cmd       = mra_pkg::CMD_ADD;
        i_operand_a = '0;
        i_operand_b = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        ring_modulus = 64'h1_0000_0000;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        ok0  = '{result: '0, range_error: 1'b0};
        err1 = '{result: '0, range_error: 1'b1};

        // directed table under the reset modulus of 2^32
        rows.push_back('{mra_pkg::CMD_ADD, 64'hFFFF_FFFF, 64'h1, 1, ok0});
        rows.push_back('{mra_pkg::CMD_ADD, 64'h1_0000_0000, 64'h0, 1, err1});
        rows.push_back('{mra_pkg::CMD_SUB, 64'h0, 64'h1, 1, '{64'hFFFF_FFFF, 1'b0}});
        rows.push_back('{mra_pkg::CMD_SUB, 64'h5, 64'h1_0000_0000, 1, err1});
        rows.push_back('{mra_pkg::CMD_MUL, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 0, ok0});
        rows.push_back('{mra_pkg::CMD_MUL, 64'hFFFF_FFFF_FFFF_FFFF, 64'h2, 1, err1});
        rows.push_back('{mra_pkg::CMD_R2S, 64'h7FFF_FFFF, 64'h0, 1,
                         '{64'h7FFF_FFFF, 1'b0}});
        rows.push_back('{mra_pkg::CMD_R2S, 64'h8000_0000, 64'h0, 1,
                         '{64'hFFFF_FFFF_8000_0000, 1'b0}});
        rows.push_back('{mra_pkg::CMD_R2S, 64'h1_0000_0000, 64'h0, 1, err1});
        rows.push_back('{mra_pkg::CMD_S2R, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1,
                         '{64'hFFFF_FFFF, 1'b0}});
        rows.push_back('{mra_pkg::CMD_S2R, 64'h8000_0000_0000_0000, 64'h0, 0, ok0});
        rows.push_back('{mra_pkg::CMD_S2R, 64'h7FFF_FFFF_FFFF_FFFF,
                         64'hFFFF_FFFF_FFFF_FFFF, 0, ok0});
        rows.push_back('{3'd5, 64'h1, 64'h1, 1, ok0});
        rows.push_back('{3'd6, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1, ok0});
        rows.push_back('{3'd7, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1, ok0});
        foreach (rows[i]) begin
            row = rows[i];
            send_op(row.cmd, row.a, row.b);
            if (row.fixed) pending_results[$] = row.want;
        end

        // odd modulus of 3, zero modulus and modulus of one
        set_modulus(64'd3);
        send_op(mra_pkg::CMD_R2S, 64'd1, 64'd0);
        send_op(mra_pkg::CMD_R2S, 64'd2, 64'd0);
        send_op(mra_pkg::CMD_S2R, 64'hFFFF_FFFF_FFFF_FFFE, 64'd0);
        set_modulus(64'd0);
        for (int c = 0; c < 8; c++) begin
            send_op(c[2:0], 64'd0, 64'd0);
            if (c < 5) pending_results[$] = err1;
        end
        set_modulus(64'd1);
        for (int c = 0; c < 5; c++) send_op(c[2:0], 64'd0, 64'd0);
        send_op(mra_pkg::CMD_S2R, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);

        // random part over several moduli including the extremes
        mod_list = '{64'd2, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001,
                     64'hFFFF_FFFF_FFFF_FFFE, 64'd12345, 64'h1_0000_0000, 64'd0, 64'd0,
                     64'd0};
        for (int p = 0; p < 9; p++) begin
            if (p >= 6) mod_list[p] = rand_word() | 64'd2;
            set_modulus(mod_list[p]);
            stall_free = (p == 4);
            for (int n = 0; n < N_RANDOM / 9; ) begin
                burst = $urandom_range(1, 20);
                for (int k = 0; k < burst; k++, n++) begin
                    cmd = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                                       : 3'($urandom_range(0, 4));
                    send_op(cmd,
                            (cmd == mra_pkg::CMD_S2R) ? rand_word()
                                                      : rand_operand(ring_modulus),
                            rand_operand(ring_modulus));
                end
                // hold off until the pipeline is empty once per phase
                if (n == burst) begin
                    idle_gap(1);
                    while (pending_results.size() != 0) @(posedge i_clk);
                end
                idle_gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 8));
            end
        end

        // drain and finish
        idle_gap(1);
        stall_free = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
